### design/pfr_pkg.sv
// Package: shared types, constants and helpers for the page frame replacement block.
`timescale 1ns / 1ps
`default_nettype none
package pfr_pkg;

  localparam int PAGE_IN_W = 8;   // page number field width
  localparam int SLOT_W    = 2;   // frame_slot field width
  localparam int CNT_W     = 32;  // tick and counter width

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVAL,
    ST_COMMIT
  } ctl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch page, bump tick, restart scan
    logic issue;    // read the frame at the scan pointer
    logic commit;   // write back the frame and load the result register
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;  // scan pointer sits on the last frame
    logic out_free;   // result register can take a new transaction
  } dp_stat_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage
`default_nettype wire

### design/pfr_if.sv
// Interfaces: page reference channel and result channel.
`timescale 1ns / 1ps
`default_nettype none
interface pfr_in_if;
  logic                         valid;
  logic                         ready;
  logic [pfr_pkg::PAGE_IN_W-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

interface pfr_out_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic [pfr_pkg::SLOT_W-1:0]    frame_slot;
  logic                          evicted_valid;
  logic [pfr_pkg::PAGE_IN_W-1:0] evicted_page;
  logic [pfr_pkg::CNT_W-1:0]     hit_count;
  logic [pfr_pkg::CNT_W-1:0]     fault_count;

  modport source (output valid, output hit, output frame_slot, output evicted_valid,
                  output evicted_page, output hit_count, output fault_count, input ready);
  modport sink   (input valid, input hit, input frame_slot, input evicted_valid,
                  input evicted_page, input hit_count, input fault_count, output ready);
endinterface
`default_nettype wire

### design/pfr_ctrl.sv
// Controller: sequences accept, frame scan, evaluation and commit.
`timescale 1ns / 1ps
`default_nettype none
module pfr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire pfr_pkg::dp_stat_t stat,
  output pfr_pkg::ctl_cmd_t      cmd
);

  pfr_pkg::ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pfr_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = pfr_pkg::ST_SCAN;
      end
      pfr_pkg::ST_SCAN: begin
        if (stat.scan_last) state_nxt = pfr_pkg::ST_EVAL;
      end
      pfr_pkg::ST_EVAL: begin
        state_nxt = pfr_pkg::ST_COMMIT;
      end
      pfr_pkg::ST_COMMIT: begin
        if (stat.out_free) state_nxt = pfr_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = pfr_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.issue   = 1'b0;
    cmd.commit  = 1'b0;
    case (state_r)
      pfr_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      pfr_pkg::ST_SCAN: begin
        cmd.issue = 1'b1;
      end
      pfr_pkg::ST_EVAL: begin
      end
      pfr_pkg::ST_COMMIT: begin
        cmd.commit = stat.out_free;
      end
      default: begin
      end
    endcase
  end

  a_commit_only_in_commit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> state_r == pfr_pkg::ST_IDLE)
    else $error("commit did not return to idle");

  a_scan_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == pfr_pkg::ST_SCAN)
    else $error("accepted transaction did not start a scan");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != pfr_pkg::ST_IDLE) |-> !cmd.capture)
    else $error("capture outside idle");

endmodule
`default_nettype wire

### design/pfr_dpath.sv
// Datapath: frame memory, scan evaluation, stamps, counters and result register.
`timescale 1ns / 1ps
`default_nettype none
module pfr_dpath #(
  parameter int NUM_FRAMES = 4,
  parameter int PAGE_BITS  = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire pfr_pkg::ctl_cmd_t             cmd,
  output pfr_pkg::dp_stat_t                  stat,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_wdata,
  input  wire logic [pfr_pkg::PAGE_IN_W-1:0] page_number,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic                               hit,
  output logic [pfr_pkg::SLOT_W-1:0]         frame_slot,
  output logic                               evicted_valid,
  output logic [pfr_pkg::PAGE_IN_W-1:0]      evicted_page,
  output logic [pfr_pkg::CNT_W-1:0]          hit_count,
  output logic [pfr_pkg::CNT_W-1:0]          fault_count
);

  localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int CW = pfr_pkg::CNT_W;
  localparam int MW = PAGE_BITS + 2 * CW;  // {page, load stamp, use stamp}

  // frame memory, valid bits in flops
  logic [MW-1:0]         mem_r [NUM_FRAMES];
  logic [NUM_FRAMES-1:0] valid_r;
  logic [MW-1:0]         rd_q_r;
  logic                  rd_vld_r;
  logic [FW-1:0]         rd_idx_r;
  logic [FW-1:0]         scan_idx_r;

  logic                  policy_r;
  logic [PAGE_BITS-1:0]  page_r;
  logic [CW-1:0]         tick_r;
  logic [CW-1:0]         hits_r;
  logic [CW-1:0]         faults_r;

  // scan results
  logic                  found_r;
  logic [FW-1:0]         hit_idx_r;
  logic [CW-1:0]         hit_load_r;
  logic                  empty_r;
  logic [FW-1:0]         empty_idx_r;
  logic [CW-1:0]         best_r;
  logic [FW-1:0]         vict_idx_r;
  logic [PAGE_BITS-1:0]  vict_page_r;

  // result register
  logic                          out_valid_r;
  logic                          o_hit_r;
  logic [pfr_pkg::SLOT_W-1:0]    o_slot_r;
  logic                          o_ev_valid_r;
  logic [pfr_pkg::PAGE_IN_W-1:0] o_ev_page_r;

  logic [CW-1:0]        in_ext;
  logic [PAGE_BITS-1:0] in_page;
  logic [PAGE_BITS-1:0] rd_page;
  logic [CW-1:0]        rd_load;
  logic [CW-1:0]        rd_use;
  logic [CW-1:0]        rd_stamp;
  logic                 rd_valid;
  logic [FW-1:0]        slot;
  logic [MW-1:0]        wr_data;
  logic [CW-1:0]        hits_nxt;
  logic [CW-1:0]        faults_nxt;
  logic [CW-1:0]        slot_ext;
  logic [CW-1:0]        ev_ext;

  assign in_ext  = CW'(page_number);
  assign in_page = in_ext[PAGE_BITS-1:0];

  assign rd_page  = rd_q_r[MW-1 -: PAGE_BITS];
  assign rd_load  = rd_q_r[2*CW-1 -: CW];
  assign rd_use   = rd_q_r[CW-1:0];
  assign rd_stamp = policy_r ? rd_use : rd_load;
  assign rd_valid = valid_r[rd_idx_r];

  assign stat.scan_last = (scan_idx_r == FW'(NUM_FRAMES - 1));
  assign stat.out_free  = !out_valid_r || out_ready;

  // commit-time selection
  always_comb begin
    hits_nxt   = hits_r;
    faults_nxt = faults_r;
    if (found_r) begin
      slot     = hit_idx_r;
      wr_data  = {page_r, hit_load_r, tick_r};
      hits_nxt = pfr_pkg::sat_inc(hits_r);
    end else begin
      slot       = empty_r ? empty_idx_r : vict_idx_r;
      wr_data    = {page_r, tick_r, tick_r};
      faults_nxt = pfr_pkg::sat_inc(faults_r);
    end
  end

  assign slot_ext = CW'(slot);
  assign ev_ext   = CW'(vict_page_r);

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_q_r <= mem_r[scan_idx_r];
    end
    if (cmd.commit) begin
      mem_r[slot] <= wr_data;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      rd_vld_r    <= 1'b0;
      scan_idx_r  <= '0;
      policy_r    <= 1'b0;
      tick_r      <= '0;
      hits_r      <= '0;
      faults_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.issue;
      if (cfg_we) policy_r <= cfg_wdata;
      if (cmd.capture) begin
        tick_r     <= pfr_pkg::sat_inc(tick_r);
        scan_idx_r <= '0;
      end else if (cmd.issue) begin
        scan_idx_r <= scan_idx_r + FW'(1);
      end
      if (cmd.commit) begin
        valid_r[slot] <= 1'b1;
        hits_r        <= hits_nxt;
        faults_r      <= faults_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // scan bookkeeping and result payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      page_r  <= in_page;
      found_r <= 1'b0;
      empty_r <= 1'b0;
    end
    if (cmd.issue) begin
      rd_idx_r <= scan_idx_r;
    end
    if (rd_vld_r) begin
      if (rd_valid && (rd_page == page_r) && !found_r) begin
        found_r    <= 1'b1;
        hit_idx_r  <= rd_idx_r;
        hit_load_r <= rd_load;
      end
      if (!rd_valid && !empty_r) begin
        empty_r     <= 1'b1;
        empty_idx_r <= rd_idx_r;
      end
      // strict less-than keeps the lowest index on ties
      if ((rd_idx_r == '0) || (rd_stamp < best_r)) begin
        best_r      <= rd_stamp;
        vict_idx_r  <= rd_idx_r;
        vict_page_r <= rd_page;
      end
    end
    if (cmd.commit) begin
      o_hit_r      <= found_r;
      o_slot_r     <= slot_ext[pfr_pkg::SLOT_W-1:0];
      o_ev_valid_r <= !found_r && !empty_r;
      o_ev_page_r  <= (!found_r && !empty_r) ? ev_ext[pfr_pkg::PAGE_IN_W-1:0] : '0;
    end
  end

  assign out_valid     = out_valid_r;
  assign hit           = o_hit_r;
  assign frame_slot    = o_slot_r;
  assign evicted_valid = o_ev_valid_r;
  assign evicted_page  = o_ev_page_r;
  assign hit_count     = hits_r;
  assign fault_count   = faults_r;

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(o_hit_r && o_ev_valid_r))
    else $error("hit reported with an eviction");

  a_ev_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !o_ev_valid_r) |-> (o_ev_page_r == '0))
    else $error("evicted page nonzero without eviction");

  a_hit_frame_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && found_r) |-> valid_r[hit_idx_r])
    else $error("hit on an empty frame");

  a_evict_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && !found_r && !empty_r) |-> (valid_r == '1))
    else $error("eviction while a frame is empty");

  a_one_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> ((hits_r != $past(hits_r)) || (faults_r != $past(faults_r))
                    || (hits_r == pfr_pkg::CNT_MAX) || (faults_r == pfr_pkg::CNT_MAX)))
    else $error("commit left both counters unchanged");

endmodule
`default_nettype wire

### design/page_frame_replacement_fifo_lru.sv
// Top level: page frame table with FIFO or LRU replacement.
//
//  channel | dir | handshake        | payload
//  in_ch   | in  | valid/ready      | page_number
//  out_ch  | out | valid/ready      | hit, frame_slot, evicted_valid, evicted_page,
//          |     |                  | hit_count, fault_count
//  cfg_*   | in  | cfg_we (no wait) | cfg_wdata = policy_mode
//
// One reference passes through an accept state, one frame memory read per frame over the
// single read port, an evaluation state for the last read and a commit state; the result
// register is loaded in the commit state.
// A result sits in an output register; the next transaction is taken while it waits.
// Commit stalls only while the output register is full and not being taken.
// Reset is synchronous, active low; all frames come up empty, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module page_frame_replacement_fifo_lru #(
  parameter int NUM_FRAMES = 4,
  parameter int PAGE_BITS  = 8
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pfr_in_if.sink     in_ch,
  pfr_out_if.source  out_ch,
  input  wire logic  cfg_we,
  input  wire logic  cfg_wdata
);

  pfr_pkg::ctl_cmd_t cmd;
  pfr_pkg::dp_stat_t stat;

  pfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pfr_dpath #(
    .NUM_FRAMES (NUM_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .page_number   (in_ch.page_number),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .hit           (out_ch.hit),
    .frame_slot    (out_ch.frame_slot),
    .evicted_valid (out_ch.evicted_valid),
    .evicted_page  (out_ch.evicted_page),
    .hit_count     (out_ch.hit_count),
    .fault_count   (out_ch.fault_count)
  );

endmodule
`default_nettype wire
